/* design/qvr_pkg.sv */
// ---------------------------------------------------------------------------
// qvr_pkg
// Shared widths and sideband types for the quaternion vector rotator.
// ---------------------------------------------------------------------------
package qvr_pkg;

  localparam int IN_W    = 32;  // every quaternion and vector part
  localparam int PROD_W  = 64;  // 32x32 signed product
  localparam int SUM_W   = 66;  // sums of up to four products
  localparam int SPLIT_W = 33;  // low slice of a wide operand
  localparam int NUM_W   = 100; // signed numerator before division
  localparam int ABS_W   = 99;  // numerator magnitude
  localparam int DEN_W   = 65;  // squared magnitude, unsigned
  localparam int QUO_W   = 33;  // quotient bits developed
  localparam int REM_W   = 66;  // partial remainder
  localparam int NCOMP   = 3;

  // sideband that travels with each transaction
  typedef struct packed {
    logic valid;
    logic zero;
  } qvr_ctl_t;

endpackage

/* design/qvr_numer.sv */
// ---------------------------------------------------------------------------
// qvr_numer
// Five-stage pipeline forming q*(0,v)*conj(q) and |q|^2 exactly.
// ---------------------------------------------------------------------------
module qvr_numer (
  input  logic                          clk,
  input  logic                          rst,
  input  qvr_pkg::qvr_ctl_t             ctl_in,
  input  logic signed [31:0]            quat_w,
  input  logic signed [31:0]            quat_x,
  input  logic signed [31:0]            quat_y,
  input  logic signed [31:0]            quat_z,
  input  logic signed [31:0]            vec_x,
  input  logic signed [31:0]            vec_y,
  input  logic signed [31:0]            vec_z,
  output qvr_pkg::qvr_ctl_t             ctl_out,
  output logic signed [qvr_pkg::NUM_W-1:0] num [qvr_pkg::NCOMP],
  output logic [qvr_pkg::DEN_W-1:0]     den
);
  import qvr_pkg::*;

  qvr_ctl_t ctl1, ctl2, ctl3, ctl4, ctl5;

  // operands carried to stage 3
  logic signed [IN_W-1:0] w1, w2;
  logic signed [IN_W-1:0] u1 [NCOMP];
  logic signed [IN_W-1:0] u2 [NCOMP];
  logic signed [IN_W-1:0] v1 [NCOMP];
  logic signed [IN_W-1:0] v2 [NCOMP];

  // stage 1 products
  logic signed [PROD_W-1:0] sq [4];
  logic signed [PROD_W-1:0] dp [NCOMP];
  logic signed [PROD_W-1:0] cp [NCOMP];
  logic signed [PROD_W-1:0] cm [NCOMP];

  // stage 2 sums
  logic signed [SUM_W-1:0] mag2, s2;
  logic signed [SUM_W-1:0] d2;
  logic signed [SUM_W-1:0] c2 [NCOMP];

  // stage 3 partial products: [k][0]=s*v, [1]=d*u, [2]=c*w
  logic signed [SUM_W-1:0] plo [NCOMP][3];
  logic signed [SUM_W-1:0] phi [NCOMP][3];
  logic [DEN_W-1:0] den3, den4;

  // stage 4 full products
  logic signed [NUM_W-1:0] prod [NCOMP][3];

  logic signed [IN_W-1:0] qin [4];
  logic signed [IN_W-1:0] vin [NCOMP];
  logic signed [IN_W-1:0] uin [NCOMP];
  logic signed [SUM_W-1:0] opa [NCOMP][3];
  logic signed [IN_W-1:0]  opb [NCOMP][3];

  assign qin = '{quat_w, quat_x, quat_y, quat_z};
  assign uin = '{quat_x, quat_y, quat_z};
  assign vin = '{vec_x, vec_y, vec_z};

  // valid and zero tags follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
      ctl4 <= '0;
      ctl5 <= '0;
    end else begin
      ctl1 <= ctl_in;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
      ctl4 <= ctl3;
      ctl5 <= ctl4;
    end
  end

  // stage 1: 32x32 products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) sq[i] <= qin[i] * qin[i];
    for (int k = 0; k < NCOMP; k++) begin
      dp[k] <= uin[k] * vin[k];
      cp[k] <= uin[(k+1)%3] * vin[(k+2)%3];
      cm[k] <= uin[(k+2)%3] * vin[(k+1)%3];
    end
    w1 <= quat_w;
    u1 <= uin;
    v1 <= vin;
  end

  // stage 2: magnitude, scalar term, dot and cross
  always_ff @(posedge clk) begin
    mag2 <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]) + SUM_W'(sq[3]);
    s2   <= SUM_W'(sq[0]) - SUM_W'(sq[1]) - SUM_W'(sq[2]) - SUM_W'(sq[3]);
    d2   <= SUM_W'(dp[0]) + SUM_W'(dp[1]) + SUM_W'(dp[2]);
    for (int k = 0; k < NCOMP; k++) c2[k] <= SUM_W'(cp[k]) - SUM_W'(cm[k]);
    w2 <= w1;
    u2 <= u1;
    v2 <= v1;
  end

  // operand pairs for the wide products
  always_comb begin
    for (int k = 0; k < NCOMP; k++) begin
      opa[k][0] = s2;    opb[k][0] = v2[k];
      opa[k][1] = d2;    opb[k][1] = u2[k];
      opa[k][2] = c2[k]; opb[k][2] = w2;
    end
  end

  // stage 3: wide operand split into two slices of about 33 bits
  always_ff @(posedge clk) begin
    for (int k = 0; k < NCOMP; k++) begin
      for (int j = 0; j < 3; j++) begin
        plo[k][j] <= $signed({1'b0, opa[k][j][SPLIT_W-1:0]}) * opb[k][j];
        phi[k][j] <= SUM_W'($signed(opa[k][j][SUM_W-1:SPLIT_W]) * opb[k][j]);
      end
    end
    den3 <= mag2[DEN_W-1:0];
  end

  // stage 4: recombine slices
  always_ff @(posedge clk) begin
    for (int k = 0; k < NCOMP; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod[k][j] <= (NUM_W'(phi[k][j]) <<< SPLIT_W) + NUM_W'(plo[k][j]);
      end
    end
    den4 <= den3;
  end

  // stage 5: (w^2-u.u)v + 2(u.v)u + 2w(u x v)
  always_ff @(posedge clk) begin
    for (int k = 0; k < NCOMP; k++) begin
      num[k] <= prod[k][0] + (prod[k][1] <<< 1) + (prod[k][2] <<< 1);
    end
    den <= den4;
  end

  assign ctl_out = ctl5;

endmodule

/* design/qvr_div.sv */
// ---------------------------------------------------------------------------
// qvr_div
// Pipelined restoring divider: magnitude stage, then one quotient bit per
// stage. The rotated length never exceeds the input length, so 33
// quotient bits cover every result.
// ---------------------------------------------------------------------------
module qvr_div (
  input  logic                              clk,
  input  logic                              rst,
  input  qvr_pkg::qvr_ctl_t                 ctl_in,
  input  logic signed [qvr_pkg::NUM_W-1:0]  num,
  input  logic [qvr_pkg::DEN_W-1:0]         den,
  output qvr_pkg::qvr_ctl_t                 ctl_out,
  output logic [qvr_pkg::QUO_W-1:0]         quo,
  output logic                              neg
);
  import qvr_pkg::*;

  qvr_ctl_t             ctl_q  [QUO_W+1];
  logic [REM_W-1:0]     rem_q  [QUO_W+1];
  logic [QUO_W-1:0]     low_q  [QUO_W+1];
  logic [QUO_W-1:0]     quo_q  [QUO_W+1];
  logic [DEN_W-1:0]     den_q  [QUO_W+1];
  logic                 neg_q  [QUO_W+1];
  logic [NUM_W-1:0]     mag;

  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  // magnitude stage
  always_ff @(posedge clk) begin
    if (rst) ctl_q[0] <= '0;
    else     ctl_q[0] <= ctl_in;
  end

  always_ff @(posedge clk) begin
    rem_q[0] <= mag[ABS_W-1:QUO_W];
    low_q[0] <= mag[QUO_W-1:0];
    quo_q[0] <= '0;
    den_q[0] <= den;
    neg_q[0] <= num[NUM_W-1];
  end

  // one trial subtraction per stage
  for (genvar g = 0; g < QUO_W; g++) begin : g_step
    logic [REM_W:0] sh;
    logic           ge;

    assign sh = {rem_q[g], low_q[g][QUO_W-1]};
    assign ge = sh >= (REM_W+1)'(den_q[g]);

    always_ff @(posedge clk) begin
      if (rst) ctl_q[g+1] <= '0;
      else     ctl_q[g+1] <= ctl_q[g];
    end

    always_ff @(posedge clk) begin
      rem_q[g+1] <= ge ? REM_W'(sh - (REM_W+1)'(den_q[g])) : REM_W'(sh);
      low_q[g+1] <= {low_q[g][QUO_W-2:0], 1'b0};
      quo_q[g+1] <= {quo_q[g][QUO_W-2:0], ge};
      den_q[g+1] <= den_q[g];
      neg_q[g+1] <= neg_q[g];
    end
  end

  assign ctl_out = ctl_q[QUO_W];
  assign quo     = quo_q[QUO_W];
  assign neg     = neg_q[QUO_W];

endmodule

/* design/quaternion_vector_rotate.sv */
// ---------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a Q15.16 vector by a Q4.27 quaternion, q*(0,v)*q^-1, exact
// numerator divided by |q|^2 with truncation, saturated to Q15.16.
// ---------------------------------------------------------------------------
//  channel   handshake        payload
//  input     start / busy     quat_w quat_x quat_y quat_z vec_x vec_y vec_z
//  result    done (1 cycle)   rot_x rot_y rot_z zero_quat saturated
//
//  One transaction per clock; busy is held low. The path has 5 numerator
//  stages, 34 divider stages (magnitude plus one quotient bit each) and one
//  saturation register. The divider's bit-per-stage chain sets the depth.
//  Synchronous rst clears all valid bits; data in flight is dropped. The
//  receiver cannot stall, so nothing ever holds.
// ---------------------------------------------------------------------------
module quaternion_vector_rotate (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] quat_w,
  input  logic signed [31:0] quat_x,
  input  logic signed [31:0] quat_y,
  input  logic signed [31:0] quat_z,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  output logic               done,
  output logic signed [31:0] rot_x,
  output logic signed [31:0] rot_y,
  output logic signed [31:0] rot_z,
  output logic               zero_quat,
  output logic               saturated
);
  import qvr_pkg::*;

  qvr_ctl_t               ctl_in, ctl_n;
  qvr_ctl_t               ctl_d [NCOMP];
  logic signed [NUM_W-1:0] num [NCOMP];
  logic [DEN_W-1:0]       den;
  logic [QUO_W-1:0]       quo [NCOMP];
  logic                   neg [NCOMP];
  logic [IN_W-1:0]        val [NCOMP];
  logic [NCOMP-1:0]       clip;

  assign busy         = 1'b0;
  assign ctl_in.valid = start;
  assign ctl_in.zero  = (quat_w == '0) && (quat_x == '0) && (quat_y == '0) && (quat_z == '0);

  qvr_numer u_numer (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_in),
    .quat_w  (quat_w),
    .quat_x  (quat_x),
    .quat_y  (quat_y),
    .quat_z  (quat_z),
    .vec_x   (vec_x),
    .vec_y   (vec_y),
    .vec_z   (vec_z),
    .ctl_out (ctl_n),
    .num     (num),
    .den     (den)
  );

  for (genvar k = 0; k < NCOMP; k++) begin : g_div
    qvr_div u_div (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_n),
      .num     (num[k]),
      .den     (den),
      .ctl_out (ctl_d[k]),
      .quo     (quo[k]),
      .neg     (neg[k])
    );
  end

  // signed result with clipping
  always_comb begin
    for (int k = 0; k < NCOMP; k++) begin
      if (neg[k]) begin
        clip[k] = quo[k] > {2'b01, {(QUO_W-2){1'b0}}};
        val[k]  = clip[k] ? {1'b1, {(IN_W-1){1'b0}}} : IN_W'(~quo[k] + 1'b1);
      end else begin
        clip[k] = quo[k] > {2'b00, {(QUO_W-2){1'b1}}};
        val[k]  = clip[k] ? {1'b0, {(IN_W-1){1'b1}}} : quo[k][IN_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= ctl_d[0].valid;
  end

  always_ff @(posedge clk) begin
    zero_quat <= ctl_d[0].zero;
    saturated <= !ctl_d[0].zero && (clip != '0);
    rot_x     <= ctl_d[0].zero ? '0 : $signed(val[0]);
    rot_y     <= ctl_d[0].zero ? '0 : $signed(val[1]);
    rot_z     <= ctl_d[0].zero ? '0 : $signed(val[2]);
  end

endmodule

/* test/quaternion_vector_rotate_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// quaternion_vector_rotate_tb
// Drives quaternion/vector transactions with random gaps, predicts each
// rotation with wide integer math (exact numerator, truncating division by
// |q|^2, Q15.16 saturation) and checks every strobed result in order.
// ---------------------------------------------------------------------------
module quaternion_vector_rotate_tb;

  typedef struct {
    logic signed [31:0] rx, ry, rz;
    logic               zq, sat;
  } rotation_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic done;
  logic signed [31:0] rot_x, rot_y, rot_z;
  logic zero_quat, saturated;

  rotation_t expected_rot[$];
  int mismatches = 0;
  int cycles = 0;

  quaternion_vector_rotate uut (.*);

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // clamp one quotient to Q15.16
  function automatic logic signed [31:0] clamp_div(logic signed [131:0] num,
                                                   logic signed [131:0] den,
                                                   ref logic sat);
    logic signed [131:0] quo;
    quo = num / den;
    if (quo > 132'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (quo < -132'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return quo[31:0];
  endfunction

  // exact rotation: (w^2-u.u)v + 2(u.v)u + 2w(u x v), divided by |q|^2
  function automatic rotation_t rotate_vec(logic signed [31:0] w, x, y, z,
                                           logic signed [31:0] vx, vy, vz);
    rotation_t r;
    logic signed [131:0] sw, sx, sy, sz, a, b, c, mag, sc, dt, cx, cy, cz;
    logic sat;
    sat = 1'b0;
    r.zq = 1'b0;
    if (w == 0 && x == 0 && y == 0 && z == 0) begin
      r.rx = '0; r.ry = '0; r.rz = '0; r.zq = 1'b1; r.sat = 1'b0;
      return r;
    end
    sw = w; sx = x; sy = y; sz = z; a = vx; b = vy; c = vz;
    mag = sw*sw + sx*sx + sy*sy + sz*sz;
    sc = sw*sw - sx*sx - sy*sy - sz*sz;
    dt = sx*a + sy*b + sz*c;
    cx = sy*c - sz*b;
    cy = sz*a - sx*c;
    cz = sx*b - sy*a;
    r.rx = clamp_div(sc*a + 2*dt*sx + 2*cx*sw, mag, sat);
    r.ry = clamp_div(sc*b + 2*dt*sy + 2*cy*sw, mag, sat);
    r.rz = clamp_div(sc*c + 2*dt*sz + 2*cz*sw, mag, sat);
    r.sat = sat;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    rotation_t e;
    if (!rst && done) begin
      if (expected_rot.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        e = expected_rot.pop_front();
        if (rot_x !== e.rx || rot_y !== e.ry || rot_z !== e.rz ||
            zero_quat !== e.zq || saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h z%b s%b got %h %h %h z%b s%b",
                     e.rx, e.ry, e.rz, e.zq, e.sat,
                     rot_x, rot_y, rot_z, zero_quat, saturated);
        end
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // send one transaction; gap of idle cycles first
  task automatic send_rotation(logic signed [31:0] w, x, y, z, vx, vy, vz, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
    vec_x <= vx; vec_y <= vy; vec_z <= vz;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_rot.push_back(rotate_vec(w, x, y, z, vx, vy, vz));
  endtask

  function automatic logic signed [31:0] rand_word();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  localparam logic signed [31:0] Q_ONE = 32'sh08000000;  // 1.0 in Q4.27
  localparam logic signed [31:0] V_ONE = 32'sh00010000;  // 1.0 in Q15.16
  localparam logic signed [31:0] HALF_R2 = 32'sh05a82799; // sqrt(0.5) Q4.27

  task automatic test_directed();
    // identity, zero quaternion, pure axis turns
    send_rotation(Q_ONE, 0, 0, 0, V_ONE, -V_ONE, 32'sh12345678, 0);
    send_rotation(0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, V_ONE, 0);
    send_rotation(0, 0, 0, 0, 0, 0, 0, 0);
    send_rotation(0, Q_ONE, 0, 0, V_ONE, V_ONE, V_ONE, 0);
    send_rotation(0, 0, Q_ONE, 0, V_ONE, V_ONE, V_ONE, 1);
    send_rotation(0, 0, 0, Q_ONE, V_ONE, V_ONE, V_ONE, 0);
    send_rotation(HALF_R2, 0, 0, HALF_R2, V_ONE, 0, 0, 0);
    send_rotation(HALF_R2, HALF_R2, 0, 0, 0, V_ONE, 0, 2);
    // extremes of every field, saturating cases
    send_rotation(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_rotation(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                  32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    send_rotation(32'sh80000000, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, 0, 0);
    send_rotation(32'sh7fffffff, 32'sh80000000, 1, -1,
                  32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
    send_rotation(1, 1, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 0, 3);
    send_rotation(1, 0, 0, 0, -1, 1, 32'sh80000000, 0);
    send_rotation(-1, 1, -1, 1, 32'sh40000000, 32'shc0000000, 32'sh7fffffff, 0);
    send_rotation(0, 0, 0, 1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
  endtask

  task automatic test_random(int n);
    logic signed [31:0] w, x, y, z;
    int sh;
    repeat (n) begin
      w = rand_word(); x = rand_word(); y = rand_word(); z = rand_word();
      // mostly random quaternions, shrunk to various scales
      if ($urandom_range(0, 3) != 0) begin
        sh = $urandom_range(3, 28);
        w = w >>> sh; x = x >>> sh; y = y >>> sh; z = z >>> sh;
        if ($urandom_range(0, 30) == 0) begin w = 0; x = 0; y = 0; z = 0; end
      end
      send_rotation(w, x, y, z, rand_word(), rand_word(), rand_word(), pick_gap());
    end
  endtask

  task automatic test_back_to_back(int n);
    repeat (n)
      send_rotation($urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1500);
    test_back_to_back(200);
    test_random(150);
    start <= 1'b0;
    while (expected_rot.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
